// ----- hw/rtl/cac_pkg.sv -----
// Shared types, codes and time arithmetic for the zone clock, alarm and countdown block.
`default_nettype none

package cac_pkg;

	localparam int NUM_ZONES_DEF  = 5;
	localparam int NUM_ALARMS_DEF = 5;

	localparam logic [1:0] REQ_TICK       = 2'd0;
	localparam logic [1:0] REQ_ADJ_ZONES  = 2'd1;
	localparam logic [1:0] REQ_ADJ_ALARM  = 2'd2;
	localparam logic [1:0] REQ_ADJ_TIMER  = 2'd3;

	localparam logic [1:0] FIELD_HOUR   = 2'd0;
	localparam logic [1:0] FIELD_MINUTE = 2'd1;
	localparam logic [1:0] FIELD_SECOND = 2'd2;

	localparam logic MODE_CLOCK = 1'b0;
	localparam logic MODE_TIMER = 1'b1;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} hms_t;

	typedef logic [4:0] hour_arr_t [16];

	localparam hour_arr_t ZONE_START_HOUR = '{
		5'd12, 5'd22, 5'd14, 5'd22, 5'd15, 5'd0, 5'd0, 5'd0,
		5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0
	};
	localparam logic [5:0] ZONE_START_MINUTE = 6'd53;
	localparam logic [5:0] ZONE_START_SECOND = 6'd32;

	localparam hms_t ALARM0_RESET = '{hour: 5'd12, minute: 6'd53, second: 6'd40};
	localparam hms_t TIMER_RESET  = '{hour: 5'd0, minute: 6'd0, second: 6'd10};

	// Step one field by one, then carry or borrow; the hour wraps within 0..23.
	function automatic hms_t hms_adjust(hms_t t, logic [1:0] sel, logic down);
		logic signed [7:0] h;
		logic signed [7:0] m;
		logic signed [7:0] s;
		logic signed [7:0] d;
		hms_t r;
		h = $signed({3'b000, t.hour});
		m = $signed({2'b00, t.minute});
		s = $signed({2'b00, t.second});
		d = down ? -8'sd1 : 8'sd1;
		case (sel)
			FIELD_HOUR:   h = h + d;
			FIELD_MINUTE: m = m + d;
			FIELD_SECOND: s = s + d;
			default: ;
		endcase
		if (s >= 8'sd60) begin
			s = 8'sd0;
			m = m + 8'sd1;
		end
		if (s < 8'sd0) begin
			s = 8'sd59;
			m = m - 8'sd1;
		end
		if (m >= 8'sd60) begin
			m = 8'sd0;
			h = h + 8'sd1;
		end
		if (m < 8'sd0) begin
			m = 8'sd59;
			h = h - 8'sd1;
		end
		if (h >= 8'sd24) h = 8'sd0;
		if (h < 8'sd0) h = 8'sd23;
		r.hour   = h[4:0];
		r.minute = m[5:0];
		r.second = s[5:0];
		return r;
	endfunction

	// Count down one second; borrow through the fields, clamp the hour at zero.
	function automatic hms_t timer_tick(hms_t t);
		logic signed [7:0] h;
		logic signed [7:0] m;
		logic signed [7:0] s;
		hms_t r;
		h = $signed({3'b000, t.hour});
		m = $signed({2'b00, t.minute});
		s = $signed({2'b00, t.second}) - 8'sd1;
		if (s >= 8'sd60) begin
			s = 8'sd0;
			m = m + 8'sd1;
		end
		if (m >= 8'sd60) begin
			m = 8'sd0;
			h = h + 8'sd1;
		end
		if (s < 8'sd0) begin
			s = 8'sd59;
			m = m - 8'sd1;
		end
		if (m < 8'sd0) begin
			m = 8'sd59;
			h = h - 8'sd1;
		end
		if (h < 8'sd0) h = 8'sd0;
		if (h > 8'sd31) h = 8'sd31;
		r.hour   = h[4:0];
		r.minute = m[5:0];
		r.second = s[5:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cac_if.sv -----
// Valid/ready channel interfaces for requests and display results.
`default_nettype none

interface cac_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [1:0] field_sel;
	logic       step_down;
	logic [2:0] alarm_index;
	logic [2:0] zone_index;

	modport source (
		output valid, req_type, field_sel, step_down, alarm_index, zone_index,
		input  ready
	);
	modport sink (
		input  valid, req_type, field_sel, step_down, alarm_index, zone_index,
		output ready
	);
endinterface

interface cac_disp_if;
	logic       valid;
	logic       ready;
	logic [4:0] shown_hour;
	logic [5:0] shown_minute;
	logic [5:0] shown_second;
	logic       alarm_hit;
	logic       timer_done;

	modport source (
		output valid, shown_hour, shown_minute, shown_second, alarm_hit, timer_done,
		input  ready
	);
	modport sink (
		input  valid, shown_hour, shown_minute, shown_second, alarm_hit, timer_done,
		output ready
	);
endinterface

`default_nettype wire

// ----- hw/rtl/clock_alarm_countdown.sv -----
// Multi-zone hh:mm:ss clock with alarms and a countdown timer, one result per request.
//
// Channels: req (sink) carries tick and adjust requests; disp (source) returns one
// display transaction per request: the selected zone (clock mode) or the timer
// (timer mode) after the request took effect, plus the alarm-hit and timer-done flags.
// cfg_we/cfg_wdata write run_mode (0 clock, 1 timer); write it only while idle.
// An accepted request goes from the request register to the display register, which
// drives disp. Throughput: one request per cycle while disp is not stalled;
// all zones update and all alarms compare in parallel in the single compute stage
// between the request register and the display register.
// Stalls: the display register holds while disp.ready is low; the request
// register still takes one more transaction, then req.ready drops until disp drains.
// Reset: zones load their start times, alarm 0 loads 12:53:40, the other alarms
// clear (off), the timer loads 00:00:10, mode returns to clock, both stages empty.
`default_nettype none

module clock_alarm_countdown import cac_pkg::*; #(
	parameter int NUM_ZONES  = NUM_ZONES_DEF,
	parameter int NUM_ALARMS = NUM_ALARMS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   cfg_we,
	input  wire logic   cfg_wdata,
	cac_req_if.sink     req,
	cac_disp_if.source  disp
);

	localparam int ZW = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
	localparam int AW = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;

	logic       mode_q;

	logic       valid_s1;
	logic [1:0] req_type_s1;
	logic [1:0] field_sel_s1;
	logic       step_down_s1;
	logic [2:0] alarm_index_s1;
	logic [2:0] zone_index_s1;

	logic       valid_s2;
	hms_t       shown_s2;
	logic       hit_s2;
	logic       done_s2;

	hms_t       zone_q  [NUM_ZONES];
	hms_t       alarm_q [NUM_ALARMS];
	hms_t       timer_q;

	hms_t       zone_nx [NUM_ZONES];
	hms_t       alarm_nx;
	hms_t       timer_nx;
	hms_t       sel_zone_nx;
	hms_t       shown_nx;
	logic       advance;
	logic       zone_ok;
	logic       alarm_ok;
	logic [ZW-1:0] zone_sel;
	logic [AW-1:0] alarm_sel;
	logic       tick;
	logic       clk_mode;
	logic       alarm_we;
	logic       hit_any;
	logic       hit_nx;
	logic       done_nx;

	assign advance   = valid_s1 && (!valid_s2 || disp.ready);
	assign req.ready = !valid_s1 || advance;

	assign zone_ok   = 32'(zone_index_s1) < NUM_ZONES;
	assign alarm_ok  = 32'(alarm_index_s1) < NUM_ALARMS;
	assign zone_sel  = zone_ok ? ZW'(zone_index_s1) : '0;
	assign alarm_sel = alarm_ok ? AW'(alarm_index_s1) : '0;
	assign tick      = req_type_s1 == REQ_TICK;
	assign clk_mode  = mode_q == MODE_CLOCK;
	assign alarm_we  = (req_type_s1 == REQ_ADJ_ALARM) && alarm_ok;

	always_comb begin
		for (int i = 0; i < NUM_ZONES; i++) begin
			if (tick && clk_mode) begin
				zone_nx[i] = hms_adjust(zone_q[i], FIELD_SECOND, 1'b0);
			end else if (req_type_s1 == REQ_ADJ_ZONES) begin
				zone_nx[i] = hms_adjust(zone_q[i], field_sel_s1, step_down_s1);
			end else begin
				zone_nx[i] = zone_q[i];
			end
		end
	end

	assign alarm_nx = hms_adjust(alarm_q[alarm_sel], field_sel_s1, step_down_s1);

	always_comb begin
		if (tick && !clk_mode) begin
			timer_nx = timer_tick(timer_q);
		end else if (req_type_s1 == REQ_ADJ_TIMER) begin
			timer_nx = hms_adjust(timer_q, field_sel_s1, step_down_s1);
		end else begin
			timer_nx = timer_q;
		end
	end

	assign sel_zone_nx = zone_nx[zone_sel];

	// An alarm at midnight counts as off.
	always_comb begin
		hit_any = 1'b0;
		for (int i = 0; i < NUM_ALARMS; i++) begin
			if ((alarm_q[i] != '0) && (alarm_q[i] == sel_zone_nx)) hit_any = 1'b1;
		end
	end

	assign hit_nx   = tick && clk_mode && hit_any;
	assign done_nx  = tick && !clk_mode && (timer_nx == '0);
	assign shown_nx = clk_mode ? sel_zone_nx : timer_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_CLOCK;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1    <= req.req_type;
			field_sel_s1   <= req.field_sel;
			step_down_s1   <= req.step_down;
			alarm_index_s1 <= req.alarm_index;
			zone_index_s1  <= req.zone_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ZONES; i++) begin
				zone_q[i].hour   <= ZONE_START_HOUR[i];
				zone_q[i].minute <= ZONE_START_MINUTE;
				zone_q[i].second <= ZONE_START_SECOND;
			end
			for (int i = 0; i < NUM_ALARMS; i++) begin
				alarm_q[i] <= (i == 0) ? ALARM0_RESET : '0;
			end
			timer_q <= TIMER_RESET;
		end else if (advance) begin
			for (int i = 0; i < NUM_ZONES; i++) begin
				zone_q[i] <= zone_nx[i];
			end
			if (alarm_we) alarm_q[alarm_sel] <= alarm_nx;
			timer_q <= timer_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || disp.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			shown_s2 <= shown_nx;
			hit_s2   <= hit_nx;
			done_s2  <= done_nx;
		end
	end

	assign disp.valid        = valid_s2;
	assign disp.shown_hour   = shown_s2.hour;
	assign disp.shown_minute = shown_s2.minute;
	assign disp.shown_second = shown_s2.second;
	assign disp.alarm_hit    = hit_s2;
	assign disp.timer_done   = done_s2;

endmodule

`default_nettype wire

// ----- hw/rtl/cac_checker.sv -----
// Port-level assertions for the clock block and the bind that attaches them.
`default_nettype none

module cac_port_props (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [4:0] shown_hour,
	input wire logic [5:0] shown_minute,
	input wire logic [5:0] shown_second,
	input wire logic       alarm_hit,
	input wire logic       timer_done
);

	// A stalled display transaction keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(shown_hour)
			&& $stable(shown_minute) && $stable(shown_second)
			&& $stable(alarm_hit) && $stable(timer_done))
		else $error("display transaction changed while stalled");

	// A request taken while the display is empty reaches it through the request and display registers.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> ##1 out_valid)
		else $error("request did not reach the display");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(alarm_hit && timer_done))
		else $error("alarm hit and timer done in one transaction");

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && timer_done |-> shown_hour == 5'd0 && shown_minute == 6'd0
			&& shown_second == 6'd0)
		else $error("timer done with a nonzero time");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> shown_hour < 5'd24 && shown_minute < 6'd60 && shown_second < 6'd60)
		else $error("displayed time out of range");

endmodule

bind clock_alarm_countdown cac_port_props u_cac_port_props (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (req.valid),
	.in_ready     (req.ready),
	.out_valid    (disp.valid),
	.out_ready    (disp.ready),
	.shown_hour   (disp.shown_hour),
	.shown_minute (disp.shown_minute),
	.shown_second (disp.shown_second),
	.alarm_hit    (disp.alarm_hit),
	.timer_done   (disp.timer_done)
);

`default_nettype wire

// ----- test/cac_checker.sv -----
// Checker for clock_alarm_countdown: predicts every display transaction and compares it.
module cac_checker
	import cac_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	cac_req_if   req,
	cac_disp_if  disp,
	output int   fails,
	output int   open_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int START_HOUR [NUM_ZONES_DEF] = '{12, 22, 14, 22, 15};

	typedef struct {
		int h;
		int m;
		int s;
	} wall_t;

	typedef struct packed {
		hms_t t;
		logic hit;
		logic done;
	} shown_t;

	wall_t  zones [NUM_ZONES_DEF];
	wall_t  alarms [NUM_ALARMS_DEF];
	wall_t  countdown;
	logic   mode;
	shown_t shown_q [$];

	function automatic int flat(wall_t t);
		return t.h * 4096 + t.m * 64 + t.s;
	endfunction

	// Carry or borrow one step out of range; the hour wraps within 0..23.
	function automatic wall_t settle(wall_t t);
		if (t.s >= 60) begin
			t.s = 0;
			t.m++;
		end
		if (t.s < 0) begin
			t.s = 59;
			t.m--;
		end
		if (t.m >= 60) begin
			t.m = 0;
			t.h++;
		end
		if (t.m < 0) begin
			t.m = 59;
			t.h--;
		end
		if (t.h >= 24) t.h = 0;
		if (t.h < 0) t.h = 23;
		return t;
	endfunction

	function automatic wall_t nudge(wall_t t, logic [1:0] sel, logic down);
		int d;
		d = down ? -1 : 1;
		case (sel)
			FIELD_HOUR:   t.h += d;
			FIELD_MINUTE: t.m += d;
			FIELD_SECOND: t.s += d;
			default: ;
		endcase
		return settle(t);
	endfunction

	// Count down one second; the hour stops at zero, so zero rolls to 00:59:59.
	function automatic wall_t count_down(wall_t t);
		t.s--;
		if (t.s < 0) begin
			t.s = 59;
			t.m--;
		end
		if (t.m < 0) begin
			t.m = 59;
			t.h--;
		end
		if (t.h < 0) t.h = 0;
		return t;
	endfunction

	function automatic shown_t apply_request(logic [1:0] kind, logic [1:0] sel, logic down,
			logic [2:0] alm, logic [2:0] zn);
		int     z;
		wall_t  w;
		shown_t r;
		r.hit  = 1'b0;
		r.done = 1'b0;
		z = (zn < NUM_ZONES_DEF) ? int'(zn) : 0;
		case (kind)
			REQ_TICK: begin
				if (mode == MODE_CLOCK) begin
					foreach (zones[i]) begin
						w = zones[i];
						w.s++;
						zones[i] = settle(w);
					end
					// an alarm at midnight is off
					foreach (alarms[i])
						if (flat(alarms[i]) != 0 && flat(alarms[i]) == flat(zones[z]))
							r.hit = 1'b1;
				end else begin
					countdown = count_down(countdown);
					r.done = (flat(countdown) == 0);
				end
			end
			REQ_ADJ_ZONES: begin
				foreach (zones[i]) zones[i] = nudge(zones[i], sel, down);
			end
			REQ_ADJ_ALARM: begin
				if (alm < NUM_ALARMS_DEF) alarms[alm] = nudge(alarms[alm], sel, down);
			end
			default: begin
				countdown = nudge(countdown, sel, down);
			end
		endcase
		w = (mode == MODE_CLOCK) ? zones[z] : countdown;
		r.t.hour   = 5'(w.h);
		r.t.minute = 6'(w.m);
		r.t.second = 6'(w.s);
		return r;
	endfunction

	function automatic void check_field(string name, logic [5:0] want, logic [5:0] got);
		if (got !== want) begin
			fails++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		shown_t got;
		shown_t want;
		if (!arst_n) begin
			foreach (zones[i]) zones[i] = '{START_HOUR[i], 53, 32};
			foreach (alarms[i]) alarms[i] = '{0, 0, 0};
			alarms[0] = '{12, 53, 40};
			countdown = '{0, 0, 10};
			mode = MODE_CLOCK;
			shown_q.delete();
			fails = 0;
			open_count <= 0;
		end else begin
			if (disp.valid && disp.ready) begin
				got.t.hour   = disp.shown_hour;
				got.t.minute = disp.shown_minute;
				got.t.second = disp.shown_second;
				got.hit      = disp.alarm_hit;
				got.done     = disp.timer_done;
				if (shown_q.size() == 0) begin
					fails++;
					$display("%0t ns: unexpected display transaction, expected none, actual %0d:%0d:%0d",
						$time, got.t.hour, got.t.minute, got.t.second);
				end else begin
					want = shown_q.pop_front();
					check_field("shown_hour", 6'(want.t.hour), 6'(got.t.hour));
					check_field("shown_minute", want.t.minute, got.t.minute);
					check_field("shown_second", want.t.second, got.t.second);
					check_field("alarm_hit", 6'(want.hit), 6'(got.hit));
					check_field("timer_done", 6'(want.done), 6'(got.done));
				end
			end
			if (cfg_we) mode = cfg_wdata;
			if (req.valid && req.ready)
				shown_q.push_back(apply_request(req.req_type, req.field_sel, req.step_down,
					req.alarm_index, req.zone_index));
			open_count <= shown_q.size();
		end
	end

endmodule

// ----- test/tb.sv -----
// Top of the clock_alarm_countdown testbench: clock, reset, request and display traffic, verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cac_pkg::*;

	localparam logic [1:0] FIELD_NONE = 2'd3;
	localparam int ITEM_TARGET = 2000;
	localparam int MAX_IDLE    = 6;
	localparam int HOLD_CYCLES = 60;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	int   check_fails;
	int   check_open;
	bit   idle_en = 1'b1;
	bit   hold_req = 1'b0;
	int   items_sent = 0;
	hms_t last_time;

	cac_req_if  req_ch ();
	cac_disp_if disp_ch ();

	clock_alarm_countdown i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.disp      (disp_ch)
	);

	cac_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req        (req_ch),
		.disp       (disp_ch),
		.fails      (check_fails),
		.open_count (check_open)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("tb NOT OK");
		$finish;
	end

	// Display side: random stalls, one long hold on request, remember the last time shown.
	initial begin : display_sink
		int stall;
		forever begin
			stall = idle_en ? $urandom_range(0, MAX_IDLE) : 0;
			if (hold_req) begin
				hold_req = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				disp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			disp_ch.ready <= 1'b1;
			do @(posedge clk); while (!disp_ch.valid);
			last_time.hour   = disp_ch.shown_hour;
			last_time.minute = disp_ch.shown_minute;
			last_time.second = disp_ch.shown_second;
		end
	end

	task automatic send_req(input logic [1:0] kind, input logic [1:0] fld, input logic dn,
			input logic [2:0] alm, input logic [2:0] zn);
		int gap;
		gap = idle_en ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.req_type    <= kind;
		req_ch.field_sel   <= fld;
		req_ch.step_down   <= dn;
		req_ch.alarm_index <= alm;
		req_ch.zone_index  <= zn;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
	endtask

	// Stop offering and wait until every display transaction is back.
	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (check_open != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_run_mode(input logic m);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Read the shown time through a request that changes nothing.
	task automatic peek(input logic [2:0] zn, output hms_t t);
		send_req(REQ_ADJ_ZONES, FIELD_NONE, 1'b0, 3'd0, zn);
		drain();
		t = last_time;
	endtask

	task automatic step_to(input logic [1:0] grp, input logic [1:0] fld, input int cur,
			input int goal, input int modulus, input logic [2:0] zn);
		int diff;
		diff = (goal - cur + modulus) % modulus;
		if (diff <= modulus / 2)
			repeat (diff) send_req(grp, fld, 1'b0, 3'($urandom_range(1, 7)), zn);
		else
			repeat (modulus - diff) send_req(grp, fld, 1'b1, 3'($urandom_range(1, 7)), zn);
	endtask

	// Walk the zones or the timer to a chosen time; seconds first, hours last.
	task automatic align(input logic [1:0] grp, input logic [2:0] zn, input int th,
			input int tm, input int ts);
		hms_t now;
		peek(zn, now);
		step_to(grp, FIELD_SECOND, int'(now.second), ts, 60, zn);
		peek(zn, now);
		step_to(grp, FIELD_MINUTE, int'(now.minute), tm, 60, zn);
		peek(zn, now);
		step_to(grp, FIELD_HOUR, int'(now.hour), th, 24, zn);
	endtask

	task automatic random_item(input logic m);
		int r;
		logic [1:0] kind;
		r = $urandom_range(0, 99);
		if (m == MODE_CLOCK)
			kind = (r < 50) ? REQ_TICK : (r < 65) ? REQ_ADJ_ZONES :
				(r < 85) ? REQ_ADJ_ALARM : REQ_ADJ_TIMER;
		else
			kind = (r < 60) ? REQ_TICK : (r < 80) ? REQ_ADJ_TIMER :
				(r < 90) ? REQ_ADJ_ZONES : REQ_ADJ_ALARM;
		// leave alarm 0 alone so the alignment target stays known
		send_req(kind, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
			3'($urandom_range(1, 7)), 3'($urandom_range(0, 7)));
	endtask

	initial begin : stimulus
		logic [2:0] tick_zn [8] = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd0, 3'd7};
		int phase;
		int k;
		int th;
		logic m;
		logic [2:0] zn;
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_wdata          <= 1'b0;
		req_ch.valid       <= 1'b0;
		req_ch.req_type    <= REQ_TICK;
		req_ch.field_sel   <= FIELD_HOUR;
		req_ch.step_down   <= 1'b0;
		req_ch.alarm_index <= 3'd0;
		req_ch.zone_index  <= 3'd0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// eighth tick brings zone 0 onto alarm 0; zones 5..7 alias zone 0
		foreach (tick_zn[i]) send_req(REQ_TICK, 2'(i % 4), 1'(i % 2), 3'(i), tick_zn[i]);
		send_req(REQ_ADJ_ALARM, FIELD_HOUR, 1'b0, 3'd0, 3'd0);
		send_req(REQ_ADJ_ALARM, FIELD_HOUR, 1'b1, 3'd0, 3'd0);
		send_req(REQ_ADJ_ALARM, FIELD_SECOND, 1'b0, 3'd7, 3'd3);
		// 00:00:00 borrows through every field to 23:59:59
		send_req(REQ_ADJ_ALARM, FIELD_SECOND, 1'b1, 3'd4, 3'd2);
		send_req(REQ_ADJ_ZONES, FIELD_HOUR, 1'b0, 3'd0, 3'd4);
		send_req(REQ_ADJ_ZONES, FIELD_SECOND, 1'b1, 3'd0, 3'd6);
		send_req(REQ_ADJ_ZONES, FIELD_NONE, 1'b0, 3'd5, 3'd1);
		send_req(REQ_ADJ_TIMER, FIELD_SECOND, 1'b1, 3'd0, 3'd0);
		drain();
		write_run_mode(MODE_TIMER);
		// nine ticks reach zero, the tenth rolls to 00:59:59
		repeat (10) send_req(REQ_TICK, FIELD_MINUTE, 1'b1, 3'd2, 3'd7);

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			drain();
			m = (phase % 3 == 2) ? MODE_TIMER : MODE_CLOCK;
			write_run_mode(m);
			idle_en = (phase % 4 != 3);
			zn = 3'($urandom_range(0, 7));
			k = $urandom_range(1, 10);
			if (m == MODE_CLOCK) begin
				if ($urandom_range(0, 1))
					align(REQ_ADJ_ZONES, zn, 12, 53, 40 - k);
				else
					align(REQ_ADJ_ZONES, zn, 23, 59, 60 - k);
			end else begin
				th = $urandom_range(0, 3) == 0 ? 1 : 0;
				align(REQ_ADJ_TIMER, zn, th, 0, k);
			end
			repeat (k + 3) send_req(REQ_TICK, 2'($urandom_range(0, 3)), 1'b0, 3'd0, zn);
			// hold the display during a long burst so the block fills and stalls requests
			if (phase == 2) hold_req = 1'b1;
			repeat (120) random_item(m);
			phase++;
		end

		drain();
		repeat (4) @(posedge clk);
		if (check_fails == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

// ----- clock_alarm_countdown.f -----
hw/rtl/cac_pkg.sv
hw/rtl/cac_if.sv
hw/rtl/clock_alarm_countdown.sv
hw/rtl/cac_checker.sv
test/cac_checker.sv
test/tb.sv
